// ===== hdl/anlp_pkg.sv =====
// ----------------------------------------------------------------------------
// anlp_pkg
// Shared types, constants and helpers for the ASCII number literal parser.
// ----------------------------------------------------------------------------
package anlp_pkg;

  localparam int WORD_BITS_DEFAULT = 32;
  localparam int VALUE_BITS        = 32;
  localparam int CFG_ADDR_BITS     = 2;
  localparam int CFG_DATA_BITS     = 32;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_NARROW_RESULT = 2'd0;

  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_LAST = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_B  = 8'h62;
  localparam logic [7:0] CHAR_LC_D  = 8'h64;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;
  localparam logic [7:0] CHAR_LC_LAST = 8'h7A;

  localparam logic [5:0] DIGIT_INVALID = 6'd63;

  typedef logic [1:0] position_t;

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (is_dec_char(c)) begin
      t = c - CHAR_ZERO;
    end else if ((c >= CHAR_UC_A) && (c <= CHAR_UC_LAST)) begin
      t = c - CHAR_UC_A + 8'd10;
    end else if ((c >= CHAR_LC_A) && (c <= CHAR_LC_LAST)) begin
      t = c - CHAR_LC_A + 8'd10;
    end else begin
      t = {2'b00, DIGIT_INVALID};
    end
    return t[5:0];
  endfunction

endpackage

// ===== hdl/ascii_number_literal_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_number_literal_parser_core
// Parses a signed integer token, one ASCII character per transaction.
// ----------------------------------------------------------------------------
// Input channel: ch with last marking the final character of a token,
// qualified by item_valid; the block holds it off with item_stall.
// Output channel: one transaction per token (value, error), qualified by
// result_valid and held off by result_stall.
// A leading '-' negates; a 0x / 0b / 0d prefix picks radix 16 / 2 / 10 when
// at least three characters follow the sign. The value wraps at WORD_BITS,
// or at 8 bits when narrow_result is set over the APB port (address 0).
// Throughput: one character per cycle while item_stall is low. The result of a
// token appears in the cycle after its last character is taken, from an output
// register loaded by the shift-add digit update.
// While a result waits under result_stall, item_stall is raised and no
// character is taken; the held result does not change.
// Reset (rst, synchronous) clears the token state (not held_zero or held_ch),
// result_valid and narrow_result; value and error are not reset.
// ----------------------------------------------------------------------------
module ascii_number_literal_parser_core #(
  parameter int WORD_BITS = anlp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [anlp_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [anlp_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [anlp_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [7:0]                          ch,
  input  logic                                last,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [anlp_pkg::VALUE_BITS-1:0]     value,
  output logic                                error
);

  logic                  narrow_result;
  logic                  negative;
  logic [4:0]            radix;
  logic [WORD_BITS-1:0]  accumulator;
  logic                  bad_token;
  anlp_pkg::position_t   position;
  logic                  held_zero;
  logic [7:0]            held_ch;

  logic                  accept;
  logic                  sign_step;
  logic                  prefix;
  logic                  prefix_bad;
  logic [4:0]            radix_use;
  logic [5:0]            dig;
  logic                  digit_bad;
  logic [WORD_BITS-1:0]  base;
  logic [WORD_BITS-1:0]  scaled;
  logic [WORD_BITS-1:0]  fed;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  signed_val;
  logic [63:0]           wide_val;

  logic                  negative_next;
  logic [4:0]            radix_next;
  logic [WORD_BITS-1:0]  accumulator_next;
  logic                  bad_token_next;
  anlp_pkg::position_t   position_next;

  assign pready = 1'b1;
  assign prdata = (paddr == anlp_pkg::ADDR_NARROW_RESULT)
                ? anlp_pkg::CFG_DATA_BITS'(narrow_result) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_result <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == anlp_pkg::ADDR_NARROW_RESULT)) begin
      narrow_result <= pwdata[0];
    end
  end

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign mask = narrow_result ? WORD_BITS'(8'hFF) : '1;

  always_comb begin
    dig        = anlp_pkg::digit_value(ch);
    sign_step  = (position == 2'd0) && !negative && (ch == anlp_pkg::CHAR_MINUS);
    prefix     = (position == 2'd2) && held_zero && !anlp_pkg::is_dec_char(held_ch) &&
                 (held_ch != anlp_pkg::CHAR_DOT);
    prefix_bad = 1'b0;
    radix_use  = radix;
    if (prefix) begin
      if (held_ch == anlp_pkg::CHAR_LC_X) begin
        radix_use = anlp_pkg::RADIX_HEX;
      end else if (held_ch == anlp_pkg::CHAR_LC_B) begin
        radix_use = anlp_pkg::RADIX_BIN;
      end else if (held_ch == anlp_pkg::CHAR_LC_D) begin
        radix_use = anlp_pkg::RADIX_DEC;
      end else begin
        radix_use  = anlp_pkg::RADIX_DEC;
        prefix_bad = 1'b1;
      end
    end
    digit_bad = dig >= {1'b0, radix_use};
    base      = prefix ? '0 : accumulator;
    unique case (radix_use)
      anlp_pkg::RADIX_BIN: scaled = base << 1;
      anlp_pkg::RADIX_HEX: scaled = base << 4;
      default:             scaled = (base << 3) + (base << 1);
    endcase
    fed = scaled + WORD_BITS'(dig);
  end

  always_comb begin
    negative_next    = negative;
    radix_next       = radix;
    accumulator_next = accumulator;
    bad_token_next   = bad_token;
    position_next    = position;
    if (sign_step) begin
      negative_next = 1'b1;
    end else if (position != 2'd3 && position != 2'd2) begin
      accumulator_next = fed;
      bad_token_next   = bad_token || digit_bad;
      position_next    = position + 2'd1;
    end else begin
      radix_next       = radix_use;
      accumulator_next = fed & mask;
      bad_token_next   = (prefix ? prefix_bad : bad_token) || digit_bad;
      position_next    = 2'd3;
    end
  end

  assign signed_val = (negative_next ? (WORD_BITS'(0) - accumulator_next)
                                     : accumulator_next) & mask;
  assign wide_val   = 64'(signed_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      negative    <= 1'b0;
      radix       <= anlp_pkg::RADIX_DEC;
      accumulator <= '0;
      bad_token   <= 1'b0;
      position    <= 2'd0;
    end else if (accept) begin
      if (last) begin
        negative    <= 1'b0;
        radix       <= anlp_pkg::RADIX_DEC;
        accumulator <= '0;
        bad_token   <= 1'b0;
        position    <= 2'd0;
      end else begin
        negative    <= negative_next;
        radix       <= radix_next;
        accumulator <= accumulator_next;
        bad_token   <= bad_token_next;
        position    <= position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !sign_step) begin
      if (position == 2'd0) begin
        held_zero <= (ch == anlp_pkg::CHAR_ZERO);
      end
      if (position == 2'd1) begin
        held_ch <= ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      value <= bad_token_next ? '0 : wide_val[anlp_pkg::VALUE_BITS-1:0];
      error <= bad_token_next;
    end
  end

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && error |-> value == '0)
    else $error("error result carries nonzero value");

  a_radix_legal: assert property (@(posedge clk) disable iff (rst)
    radix == anlp_pkg::RADIX_BIN || radix == anlp_pkg::RADIX_DEC ||
    radix == anlp_pkg::RADIX_HEX)
    else $error("radix register holds an illegal value");

  a_radix_before_prefix: assert property (@(posedge clk) disable iff (rst)
    position != 2'd3 |-> radix == anlp_pkg::RADIX_DEC)
    else $error("radix changed before prefix decision");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && last |=> result_valid)
    else $error("last character did not produce a result");

  a_token_cleared: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && last |=> position == 2'd0 && !negative && !bad_token)
    else $error("token state not cleared after last character");

endmodule
